[rtl/biop_message_header_parser_unit_assert.svh]
// Assertion macros used by the BIOP message header parser top level.
`ifndef BIOP_MESSAGE_HEADER_PARSER_UNIT_ASSERT_SVH
`define BIOP_MESSAGE_HEADER_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BIOP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("biop header parser: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BIOP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("biop header parser: next-cycle check failed");

`endif

[rtl/biop_hdr_pkg.sv]
// Types and constants shared by the BIOP message header parser modules.
package biop_hdr_pkg;

    // Number of leading object key bytes shifted into the key register.
    localparam int unsigned KEY_BYTES_KEPT = 4;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_MAGIC   = 4'd1,
        PH_VMAJ    = 4'd2,
        PH_VMIN    = 4'd3,
        PH_ORDER   = 4'd4,
        PH_TYPE    = 4'd5,
        PH_SIZE    = 4'd6,
        PH_KEYLEN  = 4'd7,
        PH_KEY     = 4'd8,
        PH_KINDLEN = 4'd9,
        PH_KIND    = 4'd10,
        PH_INFOLEN = 4'd11,
        PH_INFO    = 4'd12,
        PH_DONE    = 4'd13
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_MAGIC   = 3'd1,
        ST_BAD_VERSION = 3'd2,
        ST_BAD_ORDER   = 3'd3,
        ST_BAD_TYPE    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        KIND_FILE    = 2'd0,
        KIND_DIR     = 2'd1,
        KIND_GATEWAY = 2'd2,
        KIND_UNKNOWN = 2'd3
    } kind_t;

    typedef struct packed {
        status_t     status;
        kind_t       object_kind;
        logic [31:0] message_size;
        logic [31:0] object_key;
        logic [7:0]  key_length;
        logic [31:0] kind_length;
        logic [15:0] info_length;
    } result_t;

endpackage

[rtl/biop_hdr_parse.sv]
// Header parsing state machine and field collection registers.
module biop_hdr_parse
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    input  logic [7:0]            byte_data,
    input  logic                  byte_start,
    input  logic                  res_room,
    output logic                  advance,
    output logic                  res_load,
    output biop_hdr_pkg::result_t res
);

    localparam logic [31:0] WORD_FIL = 32'h66696C00;
    localparam logic [31:0] WORD_DIR = 32'h64697200;
    localparam logic [31:0] WORD_SRG = 32'h73726700;

    biop_hdr_pkg::phase_t phase_reg, phase_next, ph_cur;
    logic [31:0] fc_reg, fc_next, fc_cur, fc_inc;
    logic [31:0] size_reg, size_next, size_cur;
    logic [31:0] key_reg, key_next, key_cur;
    logic [7:0]  keylen_reg, keylen_next, keylen_cur;
    logic [31:0] kindlen_reg, kindlen_next, kindlen_cur;
    logic [31:0] kindw_reg, kindw_next, kindw_cur;
    logic [15:0] info_reg, info_next, info_cur;
    logic        emit;
    logic        commit;
    biop_hdr_pkg::status_t status;
    logic [7:0]  magic_byte;

    function automatic biop_hdr_pkg::kind_t classify(input logic [31:0] w);
        biop_hdr_pkg::kind_t k;
        if (w == WORD_FIL) k = biop_hdr_pkg::KIND_FILE;
        else if (w == WORD_DIR) k = biop_hdr_pkg::KIND_DIR;
        else if (w == WORD_SRG) k = biop_hdr_pkg::KIND_GATEWAY;
        else k = biop_hdr_pkg::KIND_UNKNOWN;
        return k;
    endfunction

    // A start byte clears the collected fields and is taken as the first magic byte.
    assign ph_cur      = byte_start ? biop_hdr_pkg::PH_MAGIC : phase_reg;
    assign fc_cur      = byte_start ? 32'd0 : fc_reg;
    assign size_cur    = byte_start ? 32'd0 : size_reg;
    assign key_cur     = byte_start ? 32'd0 : key_reg;
    assign keylen_cur  = byte_start ? 8'd0  : keylen_reg;
    assign kindlen_cur = byte_start ? 32'd0 : kindlen_reg;
    assign kindw_cur   = byte_start ? 32'd0 : kindw_reg;
    assign info_cur    = byte_start ? 16'd0 : info_reg;
    assign fc_inc      = fc_cur + 32'd1;

    always_comb
    begin
        case (fc_cur[1:0])
            2'd0:    magic_byte = 8'h42;
            2'd1:    magic_byte = 8'h49;
            2'd2:    magic_byte = 8'h4F;
            default: magic_byte = 8'h50;
        endcase
    end

    // Field datapath and result detection.
    always_comb
    begin
        fc_next      = fc_cur;
        size_next    = size_cur;
        key_next     = key_cur;
        keylen_next  = keylen_cur;
        kindlen_next = kindlen_cur;
        kindw_next   = kindw_cur;
        info_next    = info_cur;
        emit         = 1'b0;
        status       = biop_hdr_pkg::ST_OK;
        unique case (ph_cur) inside
            biop_hdr_pkg::PH_MAGIC:
            begin
                if (byte_data != magic_byte)
                begin
                    emit   = 1'b1;
                    status = biop_hdr_pkg::ST_BAD_MAGIC;
                end
                else
                begin
                    fc_next = (fc_cur[1:0] == 2'd3) ? 32'd0 : fc_inc;
                end
            end
            biop_hdr_pkg::PH_VMAJ:
            begin
                if (byte_data != 8'd1)
                begin
                    emit   = 1'b1;
                    status = biop_hdr_pkg::ST_BAD_VERSION;
                end
            end
            biop_hdr_pkg::PH_VMIN:
            begin
                if (byte_data != 8'd0)
                begin
                    emit   = 1'b1;
                    status = biop_hdr_pkg::ST_BAD_VERSION;
                end
            end
            biop_hdr_pkg::PH_ORDER:
            begin
                if (byte_data != 8'd0)
                begin
                    emit   = 1'b1;
                    status = biop_hdr_pkg::ST_BAD_ORDER;
                end
            end
            biop_hdr_pkg::PH_TYPE:
            begin
                if (byte_data != 8'd0)
                begin
                    emit   = 1'b1;
                    status = biop_hdr_pkg::ST_BAD_TYPE;
                end
                else
                begin
                    fc_next = 32'd0;
                end
            end
            biop_hdr_pkg::PH_SIZE:
            begin
                size_next = {size_cur[23:0], byte_data};
                fc_next   = (fc_inc >= 32'd4) ? 32'd0 : fc_inc;
            end
            biop_hdr_pkg::PH_KEYLEN:
            begin
                keylen_next = byte_data;
                fc_next     = 32'd0;
            end
            biop_hdr_pkg::PH_KEY:
            begin
                if (fc_cur < 32'(biop_hdr_pkg::KEY_BYTES_KEPT))
                begin
                    key_next = {key_cur[23:0], byte_data};
                end
                fc_next = (fc_inc >= {24'd0, keylen_cur}) ? 32'd0 : fc_inc;
            end
            biop_hdr_pkg::PH_KINDLEN:
            begin
                kindlen_next = {kindlen_cur[23:0], byte_data};
                fc_next      = (fc_inc >= 32'd4) ? 32'd0 : fc_inc;
            end
            biop_hdr_pkg::PH_KIND:
            begin
                if (fc_cur < 32'd4)
                begin
                    case (fc_cur[1:0])
                        2'd0:    kindw_next[31:24] = kindw_cur[31:24] | byte_data;
                        2'd1:    kindw_next[23:16] = kindw_cur[23:16] | byte_data;
                        2'd2:    kindw_next[15:8]  = kindw_cur[15:8]  | byte_data;
                        default: kindw_next[7:0]   = kindw_cur[7:0]   | byte_data;
                    endcase
                end
                fc_next = (fc_inc == kindlen_cur) ? 32'd0 : fc_inc;
            end
            biop_hdr_pkg::PH_INFOLEN:
            begin
                info_next = {info_cur[7:0], byte_data};
                if (fc_inc >= 32'd2)
                begin
                    fc_next = 32'd0;
                    emit    = (info_next == 16'd0);
                end
                else
                begin
                    fc_next = fc_inc;
                end
            end
            biop_hdr_pkg::PH_INFO:
            begin
                fc_next = fc_inc;
                emit    = (fc_inc >= {16'd0, info_cur});
            end
            biop_hdr_pkg::PH_IDLE, biop_hdr_pkg::PH_DONE:
            begin
                fc_next = fc_cur;
            end
            default:
            begin
                fc_next = fc_cur;
            end
        endcase
    end

    // Next phase.
    always_comb
    begin
        phase_next = ph_cur;
        if (emit)
        begin
            phase_next = biop_hdr_pkg::PH_DONE;
        end
        else
        begin
            unique case (ph_cur) inside
                biop_hdr_pkg::PH_MAGIC:
                    if (fc_cur[1:0] == 2'd3) phase_next = biop_hdr_pkg::PH_VMAJ;
                biop_hdr_pkg::PH_VMAJ:  phase_next = biop_hdr_pkg::PH_VMIN;
                biop_hdr_pkg::PH_VMIN:  phase_next = biop_hdr_pkg::PH_ORDER;
                biop_hdr_pkg::PH_ORDER: phase_next = biop_hdr_pkg::PH_TYPE;
                biop_hdr_pkg::PH_TYPE:  phase_next = biop_hdr_pkg::PH_SIZE;
                biop_hdr_pkg::PH_SIZE:
                    if (fc_inc >= 32'd4) phase_next = biop_hdr_pkg::PH_KEYLEN;
                biop_hdr_pkg::PH_KEYLEN:
                    phase_next = (byte_data != 8'd0) ? biop_hdr_pkg::PH_KEY
                                                     : biop_hdr_pkg::PH_KINDLEN;
                biop_hdr_pkg::PH_KEY:
                    if (fc_inc >= {24'd0, keylen_cur}) phase_next = biop_hdr_pkg::PH_KINDLEN;
                biop_hdr_pkg::PH_KINDLEN:
                    if (fc_inc >= 32'd4)
                    begin
                        phase_next = (kindlen_next != 32'd0) ? biop_hdr_pkg::PH_KIND
                                                             : biop_hdr_pkg::PH_INFOLEN;
                    end
                biop_hdr_pkg::PH_KIND:
                    if (fc_inc == kindlen_cur) phase_next = biop_hdr_pkg::PH_INFOLEN;
                biop_hdr_pkg::PH_INFOLEN:
                    if (fc_inc >= 32'd2) phase_next = biop_hdr_pkg::PH_INFO;
                biop_hdr_pkg::PH_INFO, biop_hdr_pkg::PH_IDLE, biop_hdr_pkg::PH_DONE:
                    phase_next = ph_cur;
                default:
                    phase_next = biop_hdr_pkg::PH_IDLE;
            endcase
        end
    end

    // A byte that produces no result always moves on; one that does needs room downstream.
    assign advance  = !emit || res_room;
    assign commit   = byte_valid && advance;
    assign res_load = commit && emit;

    assign res.status       = status;
    assign res.object_kind  = (status == biop_hdr_pkg::ST_OK) ? classify(kindw_next)
                                                              : biop_hdr_pkg::KIND_UNKNOWN;
    assign res.message_size = size_next;
    assign res.object_key   = key_next;
    assign res.key_length   = keylen_next;
    assign res.kind_length  = kindlen_next;
    assign res.info_length  = info_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= biop_hdr_pkg::PH_IDLE;
            fc_reg      <= 32'd0;
            size_reg    <= 32'd0;
            key_reg     <= 32'd0;
            keylen_reg  <= 8'd0;
            kindlen_reg <= 32'd0;
            kindw_reg   <= 32'd0;
            info_reg    <= 16'd0;
        end
        else if (commit)
        begin
            phase_reg   <= phase_next;
            fc_reg      <= fc_next;
            size_reg    <= size_next;
            key_reg     <= key_next;
            keylen_reg  <= keylen_next;
            kindlen_reg <= kindlen_next;
            kindw_reg   <= kindw_next;
            info_reg    <= info_next;
        end
    end

endmodule

[rtl/biop_hdr_outreg.sv]
// Result register that holds one header result beat until it is taken.
module biop_hdr_outreg
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  biop_hdr_pkg::result_t res_in,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic                  room,
    output biop_hdr_pkg::result_t res_out
);

    logic                  valid_reg, valid_next;
    biop_hdr_pkg::result_t res_reg;

    assign room       = !valid_reg || !out_stall;
    assign valid_next = load || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

[rtl/biop_message_header_parser_unit.sv]
// Top level of the BIOP message header parser: input register, parser and result register.
//
//   Channel  Direction  Beat contents                              Handshake
//   -------  ---------  -----------------------------------------  -----------------------
//   input    in         data_byte, message_start                   in_valid / in_stall
//   result   out        status, object_kind, message_size,         out_valid / out_stall
//                       object_key, key_length, kind_length,
//                       info_length
//
// One byte beat is accepted per cycle while in_stall is low. A byte is first captured
// in the input register and is then parsed; the byte that completes or fails the
// header loads its result beat into the result register. The parser keeps no pending
// work of its own, so each byte is finished once it leaves the input register.
// Reset (rst_n low, asynchronous) returns the parser to idle with all fields cleared;
// bytes before the first message_start produce nothing.
// in_stall rises only while a byte that yields a result waits for a full, stalled
// result register; bytes that yield no result keep flowing.
module biop_message_header_parser_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        message_start,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [1:0]  object_kind,
    output logic [31:0] message_size,
    output logic [31:0] object_key,
    output logic [7:0]  key_length,
    output logic [31:0] kind_length,
    output logic [15:0] info_length
);

`include "biop_message_header_parser_unit_assert.svh"

    // Input register: one byte beat waiting for the parser.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] byte_reg;
    logic       start_reg;
    logic       accept;

    // Handshake between parser and result register.
    logic                  advance;
    logic                  res_load;
    logic                  res_room;
    biop_hdr_pkg::result_t res_c;
    biop_hdr_pkg::result_t res_q;

    // The input register is blocked only while its byte cannot move into the parser.
    assign in_stall      = in_valid_reg && !advance;
    assign accept        = in_valid && !in_stall;
    assign in_valid_next = accept || (in_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg  <= data_byte;
            start_reg <= message_start;
        end
    end

    biop_hdr_parse u_parse
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (in_valid_reg),
        .byte_data  (byte_reg),
        .byte_start (start_reg),
        .res_room   (res_room),
        .advance    (advance),
        .res_load   (res_load),
        .res        (res_c)
    );

    biop_hdr_outreg u_outreg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .res_in    (res_c),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .room      (res_room),
        .res_out   (res_q)
    );

    assign status       = res_q.status;
    assign object_kind  = res_q.object_kind;
    assign message_size = res_q.message_size;
    assign object_key   = res_q.object_key;
    assign key_length   = res_q.key_length;
    assign kind_length  = res_q.kind_length;
    assign info_length  = res_q.info_length;

    // A result beat only appears when a byte was waiting in the input register.
    `BIOP_ASSERT_NEXT(a_result_needs_byte, clk, rst_n, !out_valid && !in_valid_reg, !out_valid)
    // Backpressure on the input comes only from a held, stalled result beat.
    `BIOP_ASSERT_IMPL(a_stall_from_output, clk, rst_n, in_stall, out_valid && out_stall)
    // A failed header never carries a classified kind.
    `BIOP_ASSERT_IMPL(a_error_kind_unknown, clk, rst_n,
        out_valid && (status != biop_hdr_pkg::ST_OK),
        object_kind == biop_hdr_pkg::KIND_UNKNOWN)

endmodule
